@@ src/cl_pkg.sv @@
package cl_pkg;

   // Token kinds shared by the classifier and the scanner
   localparam logic [5:0] KIND_END      = 6'd0;
   localparam logic [5:0] KIND_IDENT    = 6'd1;
   localparam logic [5:0] KIND_CONST    = 6'd2;
   localparam logic [5:0] KIND_UNKNOWN  = 6'd3;
   localparam logic [5:0] KIND_COMMA    = 6'd4;
   localparam logic [5:0] KIND_COLON    = 6'd5;
   localparam logic [5:0] KIND_SEMI     = 6'd6;
   localparam logic [5:0] KIND_PLUS     = 6'd7;
   localparam logic [5:0] KIND_MINUS    = 6'd8;
   localparam logic [5:0] KIND_STAR     = 6'd9;
   localparam logic [5:0] KIND_SLASH    = 6'd10;
   localparam logic [5:0] KIND_LT       = 6'd11;
   localparam logic [5:0] KIND_LE       = 6'd12;
   localparam logic [5:0] KIND_GT       = 6'd13;
   localparam logic [5:0] KIND_GE       = 6'd14;
   localparam logic [5:0] KIND_ASSIGN   = 6'd15;
   localparam logic [5:0] KIND_EQ       = 6'd16;
   localparam logic [5:0] KIND_NE       = 6'd17;
   localparam logic [5:0] KIND_LPAREN   = 6'd18;
   localparam logic [5:0] KIND_RPAREN   = 6'd19;
   localparam logic [5:0] KIND_LBRACKET = 6'd20;
   localparam logic [5:0] KIND_RBRACKET = 6'd21;
   localparam logic [5:0] KIND_LBRACE   = 6'd22;
   localparam logic [5:0] KIND_RBRACE   = 6'd23;
   localparam logic [5:0] KIND_KEYWORD0 = 6'd24;

   // Character classes found by the front end
   typedef enum logic [3:0] {
      CLASS_SPACE,
      CLASS_SINGLE,
      CLASS_LT,
      CLASS_GT,
      CLASS_EQ,
      CLASS_BANG,
      CLASS_LETTER,
      CLASS_DIGIT,
      CLASS_OTHER
   } char_class_type;

   // Classified source byte, as queued between front and back
   typedef struct packed {
      char_class_type char_class;
      logic [5:0]     single_kind;
      logic [7:0]     char_code;
      logic           end_of_input;
   } scan_item_type;

   // One result token
   typedef struct packed {
      logic [5:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic [30:0] number_value;
      logic        overflow;
      logic        last_of_run;
   } token_type;

endpackage

@@ src/cl_req_if.sv @@
interface cl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_input;

   modport source (output valid, output char_code, output end_of_input, input ready);
   modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

@@ src/cl_rsp_if.sv @@
interface cl_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [30:0] number_value;
   logic        overflow;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_start, output token_length,
                   output number_value, output overflow, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_start, input token_length,
                 input number_value, input overflow, input last_of_run, output ready);
endinterface

@@ src/c_subset_lexer.sv @@
// Streaming lexer for a small C-like language. Each req transaction carries one
// source byte or an end-of-input mark; each rsp transaction carries one token with
// its kind, start position, length and, for constants, the saturated value and an
// overflow flag. A byte yields zero, one or two tokens, and the final token of a
// byte has last_of_run set. Sustained rate is one byte per clock: a classifier
// stage feeds a two-entry queue, and the scanner retires one queued byte per
// cycle while its four-token output buffer has two free slots. A byte that
// yields two tokens needs two rsp transactions, so runs of such bytes are limited
// by the single rsp port. An accepted byte is registered in the queue and its
// tokens in the output buffer before rsp. End of input flushes any pending token,
// emits the end token and resets the position to zero so a new text can follow.
module c_subset_lexer #(
   parameter int KEYWORD_CHARS = 8,
   parameter int POSITION_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   cl_req_if.sink     req_bus,
   cl_rsp_if.source   rsp_bus
);

   logic                      item_valid;
   cl_pkg::scan_item_type     item;
   logic [POSITION_BITS-1:0]  item_pos;
   logic                      item_take;

   // Classify bytes and queue them
   cl_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item_valid (item_valid),
      .item       (item),
      .item_pos   (item_pos),
      .item_take  (item_take)
   );

   // Scan queued bytes into tokens
   cl_back #(
      .KEYWORD_CHARS (KEYWORD_CHARS),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pos   (item_pos),
      .item_take  (item_take),
      .rsp_bus    (rsp_bus)
   );

endmodule

@@ src/cl_front.sv @@
module cl_front #(
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   cl_req_if.sink                   req_bus,
   output logic                     item_valid,
   output cl_pkg::scan_item_type    item,
   output logic [POSITION_BITS-1:0] item_pos,
   input  logic                     item_take
);

   cl_pkg::scan_item_type     class_item;
   cl_pkg::scan_item_type     queue_item_ff [2];
   logic [POSITION_BITS-1:0]  queue_pos_ff [2];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                count_ff, count_in;
   logic [POSITION_BITS-1:0]  pos_ff, pos_in;
   logic                      push;
   logic                      pop;
   logic [7:0]                c;

   // Classify the incoming byte
   always_comb begin
      c = req_bus.char_code;
      class_item.char_code    = c;
      class_item.end_of_input = req_bus.end_of_input;
      class_item.single_kind  = cl_pkg::KIND_END;
      class_item.char_class   = cl_pkg::CLASS_OTHER;
      case (c)
         8'h20, 8'h09, 8'h0A, 8'h0D: class_item.char_class = cl_pkg::CLASS_SPACE;
         "<": class_item.char_class = cl_pkg::CLASS_LT;
         ">": class_item.char_class = cl_pkg::CLASS_GT;
         "=": class_item.char_class = cl_pkg::CLASS_EQ;
         "!": class_item.char_class = cl_pkg::CLASS_BANG;
         ",": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_COMMA;
         end
         ":": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_COLON;
         end
         ";": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_SEMI;
         end
         "+": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_PLUS;
         end
         "-": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_MINUS;
         end
         "*": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_STAR;
         end
         "/": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_SLASH;
         end
         "(": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_LPAREN;
         end
         ")": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_RPAREN;
         end
         "[": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_LBRACKET;
         end
         "]": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_RBRACKET;
         end
         "{": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_LBRACE;
         end
         "}": begin
            class_item.char_class  = cl_pkg::CLASS_SINGLE;
            class_item.single_kind = cl_pkg::KIND_RBRACE;
         end
         default: begin
            if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
               class_item.char_class = cl_pkg::CLASS_LETTER;
            end else if (c >= "0" && c <= "9") begin
               class_item.char_class = cl_pkg::CLASS_DIGIT;
            end
         end
      endcase
   end

   // Queue handshake
   assign req_bus.ready = (count_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign item_valid    = (count_ff != 2'd0);
   assign pop           = item_valid && item_take;
   assign item          = queue_item_ff[rd_ptr_ff];
   assign item_pos      = queue_pos_ff[rd_ptr_ff];

   // Advance pointers, count and source position
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      pos_in    = pos_ff;
      if (push) begin
         pos_in = req_bus.end_of_input ? '0 : pos_ff + {{(POSITION_BITS-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         pos_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
      end
   end

   // Hold queued transactions
   always_ff @(posedge clock) begin
      if (push) begin
         queue_item_ff[wr_ptr_ff] <= class_item;
         queue_pos_ff[wr_ptr_ff]  <= pos_ff;
      end
   end

endmodule

@@ src/cl_back.sv @@
module cl_back #(
   parameter int KEYWORD_CHARS = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  cl_pkg::scan_item_type    item,
   input  logic [POSITION_BITS-1:0] item_pos,
   output logic                     item_take,
   cl_rsp_if.source                 rsp_bus
);

   localparam int         KEYWORD_COUNT = 23;
   localparam int         IDX_BITS      = $clog2(KEYWORD_CHARS);
   localparam logic [30:0] NUMBER_MAX   = 31'h7FFF_FFFF;
   localparam logic [15:0] LENGTH_MAX   = 16'hFFFF;

   // Keywords left-justified and padded with spaces
   localparam logic [63:0] KEYWORD_TEXT [KEYWORD_COUNT] = '{
      "bool    ", "char    ", "short   ", "void    ", "int     ", "float   ",
      "double  ", "unsigned", "long    ", "if      ", "else    ", "when    ",
      "do      ", "while   ", "break   ", "switch  ", "case    ", "continue",
      "struct  ", "enum    ", "extern  ", "inline  ", "return  "
   };
   localparam logic [3:0] KEYWORD_LEN [KEYWORD_COUNT] = '{
      4'd4, 4'd4, 4'd5, 4'd4, 4'd3, 4'd5, 4'd6, 4'd8, 4'd4, 4'd2, 4'd4, 4'd4,
      4'd2, 4'd5, 4'd5, 4'd6, 4'd4, 4'd8, 4'd6, 4'd4, 4'd6, 4'd6, 4'd6
   };

   typedef enum logic [6:0] {
      MODE_IDLE = 7'b0000001,
      MODE_WORD = 7'b0000010,
      MODE_NUM  = 7'b0000100,
      MODE_LT   = 7'b0001000,
      MODE_GT   = 7'b0010000,
      MODE_EQ   = 7'b0100000,
      MODE_BANG = 7'b1000000
   } scan_mode_type;

   // Match the stored word against the keyword list
   function automatic logic [5:0] keyword_kind(input logic [63:0] chars, input logic [15:0] len);
      logic [5:0] kind;
      logic       hit;
      kind = cl_pkg::KIND_IDENT;
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
         hit = (len == {12'd0, KEYWORD_LEN[i]});
         for (int j = 0; j < 8; j++) begin
            if (j < int'(KEYWORD_LEN[i]) && chars[j*8 +: 8] != KEYWORD_TEXT[i][(7-j)*8 +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            kind = cl_pkg::KIND_KEYWORD0 + 6'(i);
         end
      end
      return kind;
   endfunction

   scan_mode_type         mode_ff, mode_in;
   logic [15:0]           len_ff, len_in;
   logic [30:0]           acc_ff, acc_in;
   logic                  sat_ff, sat_in;
   logic [15:0]           start_ff, start_in;
   logic [7:0]            word_chars_ff [KEYWORD_CHARS];
   logic                  char_wr;
   logic [IDX_BITS-1:0]   char_wr_idx;
   logic [63:0]           word_bytes;
   logic [31:0]           pos_wide;
   logic [15:0]           pos16;
   logic [34:0]           acc_next;
   cl_pkg::token_type     flush_tok;
   cl_pkg::token_type     second_tok;
   cl_pkg::token_type     tok_a;
   cl_pkg::token_type     tok_b;
   logic                  emit_flush;
   logic                  emit_second;
   logic                  push_a;
   logic                  push_b;
   cl_pkg::token_type     out_ff [4];
   logic [1:0]            wr_ptr_ff, wr_ptr_in;
   logic [1:0]            rd_ptr_ff, rd_ptr_in;
   logic [2:0]            count_ff, count_in;
   logic                  pop;

   // Take an item while two output slots are free
   assign item_take = item_valid && (count_ff <= 3'd2);
   assign pos_wide  = 32'(item_pos);
   assign pos16     = pos_wide[15:0];

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         word_bytes[j*8 +: 8] = word_chars_ff[j];
      end
   end

   // Token held by the current mode
   always_comb begin
      flush_tok              = '0;
      flush_tok.token_start  = start_ff;
      flush_tok.token_length = 16'd1;
      case (mode_ff)
         MODE_WORD: begin
            flush_tok.token_kind   = keyword_kind(word_bytes, len_ff);
            flush_tok.token_length = len_ff;
         end
         MODE_NUM: begin
            flush_tok.token_kind   = cl_pkg::KIND_CONST;
            flush_tok.token_length = len_ff;
            flush_tok.number_value = acc_ff;
            flush_tok.overflow     = sat_ff;
         end
         MODE_LT:   flush_tok.token_kind = cl_pkg::KIND_LT;
         MODE_GT:   flush_tok.token_kind = cl_pkg::KIND_GT;
         MODE_EQ:   flush_tok.token_kind = cl_pkg::KIND_ASSIGN;
         MODE_BANG: flush_tok.token_kind = cl_pkg::KIND_UNKNOWN;
         default:   flush_tok.token_kind = cl_pkg::KIND_END;
      endcase
   end

   // Scan step
   always_comb begin
      mode_in     = mode_ff;
      len_in      = len_ff;
      acc_in      = acc_ff;
      sat_in      = sat_ff;
      start_in    = start_ff;
      char_wr     = 1'b0;
      char_wr_idx = len_ff[IDX_BITS-1:0];
      emit_flush  = 1'b0;
      emit_second = 1'b0;
      second_tok  = '0;
      second_tok.token_start  = pos16;
      second_tok.token_length = 16'd1;
      acc_next    = 35'(acc_ff) * 35'd10 + 35'(item.char_code[3:0]);

      if (item.end_of_input) begin
         emit_flush              = (mode_ff != MODE_IDLE);
         emit_second             = 1'b1;
         second_tok.token_kind   = cl_pkg::KIND_END;
         second_tok.token_length = 16'd0;
         mode_in                 = MODE_IDLE;
      end else if (mode_ff == MODE_WORD && (item.char_class == cl_pkg::CLASS_LETTER ||
                                            item.char_class == cl_pkg::CLASS_DIGIT)) begin
         char_wr = (len_ff < 16'(KEYWORD_CHARS));
         if (len_ff != LENGTH_MAX) begin
            len_in = len_ff + 16'd1;
         end
      end else if (mode_ff == MODE_NUM && item.char_class == cl_pkg::CLASS_DIGIT) begin
         if (acc_next > 35'(NUMBER_MAX)) begin
            acc_in = NUMBER_MAX;
            sat_in = 1'b1;
         end else begin
            acc_in = acc_next[30:0];
         end
         if (len_ff != LENGTH_MAX) begin
            len_in = len_ff + 16'd1;
         end
      end else if ((mode_ff == MODE_LT || mode_ff == MODE_GT || mode_ff == MODE_EQ ||
                    mode_ff == MODE_BANG) && item.char_class == cl_pkg::CLASS_EQ) begin
         emit_second             = 1'b1;
         second_tok.token_start  = start_ff;
         second_tok.token_length = 16'd2;
         case (mode_ff)
            MODE_LT: second_tok.token_kind = cl_pkg::KIND_LE;
            MODE_GT: second_tok.token_kind = cl_pkg::KIND_GE;
            MODE_EQ: second_tok.token_kind = cl_pkg::KIND_EQ;
            default: second_tok.token_kind = cl_pkg::KIND_NE;
         endcase
         mode_in = MODE_IDLE;
      end else begin
         // Close the pending token, then start on this byte
         emit_flush = (mode_ff != MODE_IDLE);
         mode_in    = MODE_IDLE;
         if (item.char_class != cl_pkg::CLASS_SPACE) begin
            start_in = pos16;
         end
         case (item.char_class)
            cl_pkg::CLASS_SINGLE: begin
               emit_second           = 1'b1;
               second_tok.token_kind = item.single_kind;
            end
            cl_pkg::CLASS_OTHER: begin
               emit_second           = 1'b1;
               second_tok.token_kind = cl_pkg::KIND_UNKNOWN;
            end
            cl_pkg::CLASS_LT:   mode_in = MODE_LT;
            cl_pkg::CLASS_GT:   mode_in = MODE_GT;
            cl_pkg::CLASS_EQ:   mode_in = MODE_EQ;
            cl_pkg::CLASS_BANG: mode_in = MODE_BANG;
            cl_pkg::CLASS_LETTER: begin
               mode_in     = MODE_WORD;
               char_wr     = 1'b1;
               char_wr_idx = '0;
               len_in      = 16'd1;
            end
            cl_pkg::CLASS_DIGIT: begin
               mode_in = MODE_NUM;
               acc_in  = 31'(item.char_code[3:0]);
               sat_in  = 1'b0;
               len_in  = 16'd1;
            end
            default: mode_in = MODE_IDLE;
         endcase
      end
   end

   // Order the tokens of this transaction and mark the last one
   always_comb begin
      tok_a             = emit_flush ? flush_tok : second_tok;
      tok_a.last_of_run = !(emit_flush && emit_second);
      tok_b             = second_tok;
      tok_b.last_of_run = 1'b1;
      push_a            = item_take && (emit_flush || emit_second);
      push_b            = item_take && emit_flush && emit_second;
   end

   // Output buffer control
   assign pop            = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid  = (count_ff != 3'd0);
   assign rsp_bus.token_kind   = out_ff[rd_ptr_ff].token_kind;
   assign rsp_bus.token_start  = out_ff[rd_ptr_ff].token_start;
   assign rsp_bus.token_length = out_ff[rd_ptr_ff].token_length;
   assign rsp_bus.number_value = out_ff[rd_ptr_ff].number_value;
   assign rsp_bus.overflow     = out_ff[rd_ptr_ff].overflow;
   assign rsp_bus.last_of_run  = out_ff[rd_ptr_ff].last_of_run;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + {1'b0, push_a} + {1'b0, push_b};
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {2'b0, push_a} + {2'b0, push_b} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         len_ff    <= 16'd0;
         acc_ff    <= 31'd0;
         sat_ff    <= 1'b0;
         start_ff  <= 16'd0;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (item_take) begin
            mode_ff  <= mode_in;
            len_ff   <= len_in;
            acc_ff   <= acc_in;
            sat_ff   <= sat_in;
            start_ff <= start_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store word bytes and buffered tokens
   always_ff @(posedge clock) begin
      if (item_take && char_wr) begin
         word_chars_ff[char_wr_idx] <= item.char_code;
      end
      if (push_a) begin
         out_ff[wr_ptr_ff] <= tok_a;
      end
      if (push_b) begin
         out_ff[wr_ptr_ff + 2'd1] <= tok_b;
      end
   end

endmodule

@@ sim/tb_c_subset_lexer.sv @@
`timescale 1ns / 100ps

module tb_c_subset_lexer;

   localparam int KEYWORD_CHARS   = 8;
   localparam int KEYWORD_COUNT   = 23;
   localparam int LONG_WORD_CHARS = 40;
   localparam int DRAIN_LIMIT     = 20000;

   localparam logic [30:0] VALUE_MAX  = 31'h7FFF_FFFF;
   localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

   // Marks a byte that is not single-character punctuation
   localparam logic [5:0] KIND_NONE     = 6'd0;

   typedef enum logic [6:0] {
      SCAN_IDLE   = 7'b0000001,
      SCAN_WORD   = 7'b0000010,
      SCAN_NUMBER = 7'b0000100,
      SCAN_LT     = 7'b0001000,
      SCAN_GT     = 7'b0010000,
      SCAN_EQ     = 7'b0100000,
      SCAN_BANG   = 7'b1000000
   } scan_mode_type;

   string keyword_text [KEYWORD_COUNT] = '{
      "bool", "char", "short", "void", "int", "float", "double", "unsigned",
      "long", "if", "else", "when", "do", "while", "break", "switch", "case",
      "continue", "struct", "enum", "extern", "inline", "return"
   };
   string operator_text [8] = '{"<=", ">=", "==", "!=", "<", ">", "=", "!"};
   string letter_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string alnum_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string punct_set  = ",:;+-*/()[]{}";
   string space_set  = " \t\n\r";

   logic clock = 1'b0;
   logic reset;

   cl_req_if req_bus ();
   cl_rsp_if rsp_bus ();

   c_subset_lexer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // Scanner state mirrored by the predictor
   scan_mode_type scan_mode;
   logic [7:0]    word_chars [KEYWORD_CHARS];
   logic [15:0]   word_length;
   logic [30:0]   number_value;
   logic          number_saturated;
   logic [15:0]   position_count;
   logic [15:0]   token_origin;

   cl_pkg::token_type expected_tokens [$];
   cl_pkg::token_type byte_tokens [$];

   int error_count  = 0;
   int token_count  = 0;
   int bytes_sent   = 0;
   int burst_left   = 0;
   int gap_max      = 0;
   int stall_max    = 0;
   int hold_cycles  = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at token %0d: %s got %0d, expected %0d", token_count, what, got, want);
      error_count++;
   endtask

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [5:0] punct_kind(logic [7:0] c);
      case (c)
         ",": return cl_pkg::KIND_COMMA;
         ":": return cl_pkg::KIND_COLON;
         ";": return cl_pkg::KIND_SEMI;
         "+": return cl_pkg::KIND_PLUS;
         "-": return cl_pkg::KIND_MINUS;
         "*": return cl_pkg::KIND_STAR;
         "/": return cl_pkg::KIND_SLASH;
         "(": return cl_pkg::KIND_LPAREN;
         ")": return cl_pkg::KIND_RPAREN;
         "[": return cl_pkg::KIND_LBRACKET;
         "]": return cl_pkg::KIND_RBRACKET;
         "{": return cl_pkg::KIND_LBRACE;
         "}": return cl_pkg::KIND_RBRACE;
         default: return KIND_NONE;
      endcase
   endfunction

   function automatic void add_token(logic [5:0] kind, logic [15:0] start, logic [15:0] length,
                                     logic [30:0] value, logic saturated);
      cl_pkg::token_type t;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = length;
      t.number_value = value;
      t.overflow     = saturated;
      t.last_of_run  = 1'b0;
      byte_tokens.push_back(t);
   endfunction

   // Match the held word against the keyword table
   function automatic logic [5:0] word_kind();
      logic same;
      if (word_length > KEYWORD_CHARS) return cl_pkg::KIND_IDENT;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         if (keyword_text[k].len() == word_length) begin
            same = 1'b1;
            for (int i = 0; i < keyword_text[k].len(); i++)
               if (word_chars[i] != keyword_text[k][i]) same = 1'b0;
            if (same) return cl_pkg::KIND_KEYWORD0 + 6'(k);
         end
      end
      return cl_pkg::KIND_IDENT;
   endfunction

   // Emit whatever token the current mode holds and drop back to idle
   function automatic void close_token();
      case (scan_mode)
         SCAN_WORD:   add_token(word_kind(), token_origin, word_length, '0, 1'b0);
         SCAN_NUMBER: add_token(cl_pkg::KIND_CONST, token_origin, word_length, number_value,
                                number_saturated);
         SCAN_LT:     add_token(cl_pkg::KIND_LT, token_origin, 16'd1, '0, 1'b0);
         SCAN_GT:     add_token(cl_pkg::KIND_GT, token_origin, 16'd1, '0, 1'b0);
         SCAN_EQ:     add_token(cl_pkg::KIND_ASSIGN, token_origin, 16'd1, '0, 1'b0);
         SCAN_BANG:   add_token(cl_pkg::KIND_UNKNOWN, token_origin, 16'd1, '0, 1'b0);
         default: ;
      endcase
      scan_mode = SCAN_IDLE;
   endfunction

   // Start a new token from idle
   function automatic void open_token(logic [7:0] c, logic [15:0] pos);
      logic [5:0] kind;
      if (c == " " || c == "\t" || c == "\n" || c == "\r") return;
      token_origin = pos;
      kind = punct_kind(c);
      if (kind != KIND_NONE) begin
         add_token(kind, pos, 16'd1, '0, 1'b0);
      end else if (c == "<") begin
         scan_mode = SCAN_LT;
      end else if (c == ">") begin
         scan_mode = SCAN_GT;
      end else if (c == "=") begin
         scan_mode = SCAN_EQ;
      end else if (c == "!") begin
         scan_mode = SCAN_BANG;
      end else if (is_letter(c)) begin
         scan_mode     = SCAN_WORD;
         word_chars[0] = c;
         word_length   = 16'd1;
      end else if (is_digit(c)) begin
         scan_mode        = SCAN_NUMBER;
         number_value     = 31'(c - "0");
         number_saturated = 1'b0;
         word_length      = 16'd1;
      end else begin
         add_token(cl_pkg::KIND_UNKNOWN, pos, 16'd1, '0, 1'b0);
      end
   endfunction

   function automatic void reset_scanner();
      scan_mode        = SCAN_IDLE;
      word_length      = '0;
      number_value     = '0;
      number_saturated = 1'b0;
      position_count   = '0;
      token_origin     = '0;
      expected_tokens.delete();
   endfunction

   // Work out the tokens that one accepted byte produces
   function automatic void lex_byte(logic [7:0] c, logic eoi);
      logic [15:0]       pos;
      logic [35:0]       grown;
      cl_pkg::token_type t;
      byte_tokens.delete();
      pos = position_count;
      if (eoi) begin
         close_token();
         add_token(cl_pkg::KIND_END, pos, 16'd0, '0, 1'b0);
         position_count = '0;
      end else begin
         case (scan_mode)
            SCAN_WORD: begin
               if (is_letter(c) || is_digit(c)) begin
                  if (word_length < KEYWORD_CHARS) word_chars[word_length] = c;
                  if (word_length != LENGTH_MAX) word_length++;
               end else begin
                  close_token();
                  open_token(c, pos);
               end
            end
            SCAN_NUMBER: begin
               if (is_digit(c)) begin
                  grown = 36'(number_value) * 36'd10 + 36'(c - "0");
                  if (grown > 36'(VALUE_MAX)) begin
                     grown            = 36'(VALUE_MAX);
                     number_saturated = 1'b1;
                  end
                  number_value = grown[30:0];
                  if (word_length != LENGTH_MAX) word_length++;
               end else begin
                  close_token();
                  open_token(c, pos);
               end
            end
            SCAN_LT, SCAN_GT, SCAN_EQ, SCAN_BANG: begin
               if (c == "=") begin
                  add_token(scan_mode == SCAN_LT ? cl_pkg::KIND_LE :
                            scan_mode == SCAN_GT ? cl_pkg::KIND_GE :
                            scan_mode == SCAN_EQ ? cl_pkg::KIND_EQ : cl_pkg::KIND_NE,
                            token_origin, 16'd2, '0, 1'b0);
                  scan_mode = SCAN_IDLE;
               end else begin
                  close_token();
                  open_token(c, pos);
               end
            end
            default: begin
               scan_mode = SCAN_IDLE;
               open_token(c, pos);
            end
         endcase
         position_count = pos + 16'd1;
      end
      // Flag the final token of this byte
      if (byte_tokens.size() > 0) begin
         t = byte_tokens.pop_back();
         t.last_of_run = 1'b1;
         byte_tokens.push_back(t);
      end
      foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
   endfunction

   // Predict on every accepted request transaction
   always @(posedge clock) begin
      if (reset) begin
         reset_scanner();
      end else if (req_bus.valid && req_bus.ready) begin
         lex_byte(req_bus.char_code, req_bus.end_of_input);
      end
   end

   // Compare every accepted response transaction with the oldest expectation
   always @(posedge clock) begin
      cl_pkg::token_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         token_count++;
         if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected token, kind", rsp_bus.token_kind, 0);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_bus.token_kind !== want.token_kind)
               report_mismatch("token_kind", rsp_bus.token_kind, want.token_kind);
            if (rsp_bus.token_start !== want.token_start)
               report_mismatch("token_start", rsp_bus.token_start, want.token_start);
            if (rsp_bus.token_length !== want.token_length)
               report_mismatch("token_length", rsp_bus.token_length, want.token_length);
            if (rsp_bus.number_value !== want.number_value)
               report_mismatch("number_value", rsp_bus.number_value, want.number_value);
            if (rsp_bus.overflow !== want.overflow)
               report_mismatch("overflow", rsp_bus.overflow, want.overflow);
            if (rsp_bus.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", rsp_bus.last_of_run, want.last_of_run);
         end
      end
   end

   // Receiver: random ready and stall runs, plus a long counted hold-off
   initial begin
      int ready_run;
      int stall_run;
      ready_run     = 0;
      stall_run     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            hold_cycles--;
         end else if (stall_run > 0) begin
            rsp_bus.ready = 1'b0;
            stall_run--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (ready_run > 0) begin
               ready_run--;
            end else begin
               ready_run = $urandom_range(0, 24);
               stall_run = (stall_max > 0) ? $urandom_range(1, stall_max) : 0;
            end
         end
      end
   end

   // Offer one byte in bursts with random gaps; return once it is accepted
   task automatic send_byte(input logic [7:0] c, input logic eoi);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid        = 1'b1;
      req_bus.char_code    = eoi ? 8'($urandom_range(0, 255)) : c;
      req_bus.end_of_input = eoi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic end_text();
      send_byte(8'h00, 1'b1);
   endtask

   task automatic send_space();
      send_byte(space_set[$urandom_range(0, space_set.len() - 1)], 1'b0);
   endtask

   // Drop valid and hold until every expected token has arrived or the guard runs out
   task automatic wait_drained();
      int guard;
      guard = 0;
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_tokens.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // One random lexeme: mostly well-formed, some noise and early ends
   task automatic send_random_token();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         send_text(keyword_text[$urandom_range(0, KEYWORD_COUNT - 1)]);
         if ($urandom_range(0, 4) == 0)
            send_byte(alnum_set[$urandom_range(0, alnum_set.len() - 1)], 1'b0);
         if ($urandom_range(0, 3) != 0) send_space();
      end else if (pick < 35) begin
         n = $urandom_range(1, 12);
         send_byte(letter_set[$urandom_range(0, letter_set.len() - 1)], 1'b0);
         repeat (n - 1) send_byte(alnum_set[$urandom_range(0, alnum_set.len() - 1)], 1'b0);
         if ($urandom_range(0, 3) != 0) send_space();
      end else if (pick < 50) begin
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 5);
         repeat (n) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
         if ($urandom_range(0, 3) != 0) send_space();
      end else if (pick < 65) begin
         send_text(operator_text[$urandom_range(0, 7)]);
      end else if (pick < 78) begin
         send_byte(punct_set[$urandom_range(0, punct_set.len() - 1)], 1'b0);
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 3)) send_space();
      end else if (pick < 97) begin
         send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         end_text();
      end
   endtask

   // Extreme bytes, two-character operators, lone bang, number into word, overflow
   task automatic test_directed_edges();
      gap_max   = 0;
      stall_max = 0;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("<=a>=9z==!=! 2147483648");
      end_text();
      wait_drained();
   endtask

   task automatic test_random_text(input int count, input int gaps, input int stalls);
      int target;
      gap_max   = gaps;
      stall_max = stalls;
      target    = bytes_sent + count;
      while (bytes_sent < target) send_random_token();
      end_text();
      wait_drained();
   endtask

   // Stop the receiver for a long stretch while bytes keep coming
   task automatic test_receiver_hold();
      gap_max   = 0;
      stall_max = 0;
      send_text("v");
      hold_cycles = 300;
      repeat (10) send_text("=42;v");
      send_text(">=(x)");
      end_text();
      wait_drained();
   endtask

   // Pause mid-text with a number pending, then carry on
   task automatic test_pause_midtext();
      gap_max   = 3;
      stall_max = 4;
      send_text("while(n>=10");
      wait_drained();
      send_text("){n=n-1;}");
      end_text();
      wait_drained();
   endtask

   // Word well past the keyword buffer, followed by more tokens
   task automatic test_long_word();
      gap_max   = 0;
      stall_max = 0;
      send_byte("w", 1'b0);
      repeat (LONG_WORD_CHARS - 1)
         send_byte(alnum_set[$urandom_range(0, alnum_set.len() - 1)], 1'b0);
      send_text("=12;");
      end_text();
      wait_drained();
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.char_code    = 8'h00;
      req_bus.end_of_input = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_random_text(150, 0, 0);
      test_random_text(150, 6, 0);
      test_random_text(150, 0, 8);
      test_random_text(150, 4, 16);
      test_receiver_hold();
      test_pause_midtext();
      test_long_word();

      wait_drained();
      repeat (10) @(posedge clock);
      if (expected_tokens.size() != 0)
         report_mismatch("tokens never produced", expected_tokens.size(), 0);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Bound the run
   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
